@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the codec modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define UFPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define UFPC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define UFPC_ASSERT(lbl, prop, msg)
`define UFPC_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/ufpc_pkg.sv @@
`default_nettype none

package ufpc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned JobBytes = 3;
  localparam int unsigned CntW     = 2;
  localparam int unsigned IdxW     = 2;

  // Characters with a role in the coding
  localparam logic [ByteW-1:0] ChPercent = 8'h25;
  localparam logic [ByteW-1:0] ChPlus    = 8'h2B;
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChStar    = 8'h2A;
  localparam logic [ByteW-1:0] ChDash    = 8'h2D;
  localparam logic [ByteW-1:0] ChDot     = 8'h2E;
  localparam logic [ByteW-1:0] ChUnder   = 8'h5F;

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // Escape assembly state of the decoder
  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhPct   = 2'd1,
    PhDigit = 2'd2
  } phase_e;

  // One to three output bytes caused by one input word, first byte in data[0]
  typedef struct packed {
    logic [JobBytes-1:0][ByteW-1:0] data;
    logic [CntW-1:0]                cnt;
    logic                           last;
  } job_t;

  // Uppercase hex character for a nibble
  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib);
    logic [ByteW-1:0] res;
    if (nib < 4'd10) begin
      res = {4'h3, nib};
    end else begin
      res = 8'h37 + {4'h0, nib};
    end
    return res;
  endfunction

  // Digit value of a hex character: bit 4 flags a valid digit (0-9, A-F)
  function automatic logic [4:0] hex_value(input logic [ByteW-1:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      res = {1'b1, c[3:0] + 4'd9};
    end
    return res;
  endfunction

  // Characters passed through unchanged by the encoder
  function automatic logic is_safe(input logic [ByteW-1:0] c);
    logic res;
    res = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h61 && c <= 8'h7A) || c == ChStar || c == ChDash ||
          c == ChDot || c == ChUnder;
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/url_form_percent_codec_top.sv @@
`default_nettype none
// Channel  Handshake            Payload
// input    in_valid_i/in_stall_o   in_byte_i[7:0], in_last_i
// output   out_valid_o/out_stall_i out_byte_o[7:0], out_last_o
// config   cfg_valid_i/cfg_ready_o cfg_direction_i (0 encode, 1 decode)
//
// One input byte is taken per cycle while the word queue has room; the back end
// sends one output byte per cycle unless out_stall_i holds it, three for an escaped byte.
// With the back end idle, a byte goes via the queue memory into the output register.
// Reset clears direction to encode and the escape state; no clearing pass is needed.
// A stall on the output only backs up the queue; the input stalls once it is full.

module url_form_percent_codec_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [ufpc_pkg::ByteW-1:0]  in_byte_i,
  input  wire logic                        in_last_i,
  output logic                             in_stall_o,
  output logic                             out_valid_o,
  output logic [ufpc_pkg::ByteW-1:0]       out_byte_o,
  output logic                             out_last_o,
  input  wire logic                        out_stall_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_direction_i
);

  ufpc_pkg::job_t push_job;
  ufpc_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  ufpc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_byte_i       (in_byte_i),
    .in_last_i       (in_last_i),
    .in_stall_o      (in_stall_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_direction_i (cfg_direction_i),
    .queue_full_i    (full),
    .push_o          (push),
    .job_o           (push_job)
  );

  ufpc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  ufpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .head_valid_i (!empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

`default_nettype wire

@@ rtl/ufpc_front.sv @@
`default_nettype none

module ufpc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [ufpc_pkg::ByteW-1:0]  in_byte_i,
  input  wire logic                        in_last_i,
  output logic                             in_stall_o,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_direction_i,
  input  wire logic                        queue_full_i,
  output logic                             push_o,
  output ufpc_pkg::job_t                   job_o
);

  logic                       dir_q, dir_d;
  ufpc_pkg::phase_e           phase_q, phase_d;
  logic [ufpc_pkg::ByteW-1:0] held_q, held_d;
  logic                       accept;
  logic                       idle_pct;
  logic                       idle_emit;
  logic [ufpc_pkg::ByteW-1:0] idle_byte;
  logic [4:0]                 hv_b;
  logic [4:0]                 hv_h;
  ufpc_pkg::job_t             job;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // Classify the incoming byte as if no escape were pending
  assign hv_b      = ufpc_pkg::hex_value(in_byte_i);
  assign hv_h      = ufpc_pkg::hex_value(held_q);
  assign idle_pct  = in_byte_i == ufpc_pkg::ChPercent;
  assign idle_emit = !(idle_pct && !in_last_i);
  assign idle_byte = (in_byte_i == ufpc_pkg::ChPlus) ? ufpc_pkg::ChSpace : in_byte_i;

  // Next direction and escape state
  always_comb begin
    dir_d   = dir_q;
    phase_d = phase_q;
    held_d  = held_q;
    if (cfg_valid_i) begin
      dir_d   = cfg_direction_i;
      phase_d = ufpc_pkg::PhIdle;
      held_d  = '0;
    end else if (accept && dir_q == ufpc_pkg::DirDecode) begin
      phase_d = (idle_pct && !in_last_i) ? ufpc_pkg::PhPct : ufpc_pkg::PhIdle;
      unique case (phase_q)
        ufpc_pkg::PhPct: begin
          if (hv_b[4] && !in_last_i) begin
            phase_d = ufpc_pkg::PhDigit;
            held_d  = in_byte_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output bytes caused by the incoming byte
  always_comb begin
    job      = '0;
    job.last = in_last_i;
    if (dir_q == ufpc_pkg::DirEncode) begin
      if (in_byte_i == ufpc_pkg::ChSpace) begin
        job.data[0] = ufpc_pkg::ChPlus;
        job.cnt     = 2'd1;
      end else if (ufpc_pkg::is_safe(in_byte_i)) begin
        job.data[0] = in_byte_i;
        job.cnt     = 2'd1;
      end else begin
        job.data[0] = ufpc_pkg::ChPercent;
        job.data[1] = ufpc_pkg::hex_char(in_byte_i[7:4]);
        job.data[2] = ufpc_pkg::hex_char(in_byte_i[3:0]);
        job.cnt     = 2'd3;
      end
    end else begin
      unique case (phase_q)
        ufpc_pkg::PhPct: begin
          if (hv_b[4]) begin
            job.data[0] = in_byte_i;
            job.cnt     = in_last_i ? 2'd1 : 2'd0;
          end else begin
            job.data[0] = idle_byte;
            job.cnt     = {1'b0, idle_emit};
          end
        end
        ufpc_pkg::PhDigit: begin
          if (hv_b[4] && hv_h[4]) begin
            job.data[0] = {hv_h[3:0], hv_b[3:0]};
            job.cnt     = 2'd1;
          end else begin
            // drop the escape: the held digit goes out as a plain byte
            job.data[0] = held_q;
            job.data[1] = idle_byte;
            job.cnt     = idle_emit ? 2'd2 : 2'd1;
          end
        end
        default: begin
          job.data[0] = idle_byte;
          job.cnt     = {1'b0, idle_emit};
        end
      endcase
    end
  end

  assign push_o = accept && job.cnt != 2'd0;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= ufpc_pkg::DirEncode;
      phase_q <= ufpc_pkg::PhIdle;
      held_q  <= '0;
    end else begin
      dir_q   <= dir_d;
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ufpc_queue.sv @@
`default_nettype none
`include "assert_macros.svh"

module ufpc_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  ufpc_pkg::job_t      data_i,
  input  wire logic           pop_i,
  output ufpc_pkg::job_t      data_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntQW = $clog2(Depth + 1);

  ufpc_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] count_q, count_d;

  assign full_o  = count_q == CntQW'(Depth);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `UFPC_NEVER(a_no_push_full, push_i && full_o, "queue pushed while full")
  `UFPC_NEVER(a_no_pop_empty, pop_i && empty_o, "queue popped while empty")
  `UFPC_ASSERT(a_count_up, push_i && !pop_i |=> count_q == CntQW'($past(count_q) + 1'b1), "queue fill level lost a push")

endmodule

`default_nettype wire

@@ rtl/ufpc_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module ufpc_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  ufpc_pkg::job_t                   head_i,
  input  wire logic                        head_valid_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  output logic [ufpc_pkg::ByteW-1:0]       out_byte_o,
  output logic                             out_last_o,
  input  wire logic                        out_stall_i
);

  ufpc_pkg::job_t             job_q, job_d;
  logic                       job_valid_q, job_valid_d;
  logic [ufpc_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                       out_valid_q, out_valid_d;
  logic [ufpc_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic                       out_last_q, out_last_d;
  ufpc_pkg::job_t             cur;
  logic [ufpc_pkg::IdxW-1:0]  cur_idx;
  logic                       cur_valid;
  logic                       cur_final;
  logic                       can_load;

  // Work from the held word if one is part sent, else straight from the queue head
  assign cur       = job_valid_q ? job_q : head_i;
  assign cur_idx   = job_valid_q ? idx_q : '0;
  assign cur_valid = job_valid_q || head_valid_i;
  assign cur_final = cur_idx == ufpc_pkg::IdxW'(cur.cnt - 2'd1);
  assign can_load  = !out_valid_q || !out_stall_i;

  // Send one byte per cycle into the output register unless it is stalled
  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    if (can_load) begin
      out_valid_d = cur_valid;
      if (cur_valid) begin
        out_byte_d = cur.data[cur_idx];
        out_last_d = cur.last && cur_final;
        if (job_valid_q) begin
          if (cur_final) begin
            job_valid_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          pop_o = 1'b1;
          if (!cur_final) begin
            job_valid_d = 1'b1;
            job_d       = head_i;
            idx_d       = ufpc_pkg::IdxW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  `UFPC_ASSERT(a_idx_in_range, job_valid_q |-> idx_q < ufpc_pkg::IdxW'(job_q.cnt), "byte index beyond word length")
  `UFPC_ASSERT(a_idx_not_first, job_valid_q |-> idx_q != '0, "held word restarted at its first byte")
  `UFPC_NEVER(a_pop_while_held, pop_o && job_valid_q, "queue popped while a word is still held")

endmodule

`default_nettype wire
